### src/ddkmd_pkg.sv
package ddkmd_pkg;

  // Matrix geometry. Only eight lines per side are kept because each stored
  // row is eight bits wide.
  localparam int ROW_LINES   = 8;
  localparam int COL_LINES   = 8;
  localparam int KEPT_LINES  = 8;
  localparam int HALF_ROWS   = 8;
  localparam int TOTAL_ROWS  = 16;

  localparam int KEPT_ROWS = (ROW_LINES < KEPT_LINES) ? ROW_LINES : KEPT_LINES;
  localparam int KEPT_COLS = (COL_LINES < KEPT_LINES) ? COL_LINES : KEPT_LINES;

  localparam int LINE_W    = 3;
  localparam int KEY_W     = 8;
  localparam int ROW_NUM_W = 4;
  localparam int CNT_W     = 8;

  localparam logic [KEY_W-1:0] ROW_MASK = KEY_W'((9'd1 << KEPT_ROWS) - 9'd1);
  localparam logic [KEY_W-1:0] COL_MASK = KEY_W'((9'd1 << KEPT_COLS) - 9'd1);

  localparam logic [CNT_W-1:0]     DEBOUNCE_RESET = 8'd2;
  localparam logic [ROW_NUM_W-1:0] LAST_ROW_NUM   = ROW_NUM_W'(TOTAL_ROWS - 1);

  // Command queue between front and back.
  localparam int QUEUE_DEPTH  = 2;
  localparam int QUEUE_PTR_W  = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W  = $clog2(QUEUE_DEPTH + 1);

  // Register port.
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam logic REG_DEBOUNCE_SCANS = 1'b0;

  typedef enum logic {
    DIR_ROWS = 1'b0,
    DIR_COLS = 1'b1
  } dir_e;

  typedef struct packed {
    logic              direction;
    logic [LINE_W-1:0] line_index;
    logic [KEY_W-1:0]  pin_levels;
    logic              end_of_half;
  } in_item_t;

  typedef struct packed {
    logic [ROW_NUM_W-1:0] row_number;
    logic [KEY_W-1:0]     row_keys;
    logic                 last_row;
  } out_item_t;

  // A classified line sample: pressed bits already inverted and masked.
  typedef struct packed {
    dir_e              dir;
    logic              line_ok;
    logic [LINE_W-1:0] line;
    logic [KEY_W-1:0]  keys;
    logic              eoh;
  } cmd_t;

endpackage

### src/dual_direction_key_matrix_debouncer.sv
// Two-direction keyboard matrix debouncer. Each input transfer carries one
// sampled matrix line with active-low pin levels; in the row-driven direction
// the pressed bits are compared with that row of the lower half of a 16-row
// debounced matrix, and in the column-driven direction they are transposed
// into a column-to-row buffer that is compared with the upper half when the
// end_of_half flag marks the last line of the half scan. Any change reloads a
// shared countdown with the debounce_scans register (address 0, reset 2);
// the countdown steps at every end of half, and when it reaches zero the
// whole matrix is published as sixteen output transfers, rows 0 to 15, with
// last_row set on row 15. A stable matrix is published only once. An item
// passes an input register, a two-entry command queue and the state update
// in the back end, at a sustained rate of one item per cycle outside a
// publication; a publication occupies the back end for sixteen rows (one
// row per cycle through the output register while the consumer is ready),
// during which the queue and the input register absorb up to three further
// items before the input stalls.
module dual_direction_key_matrix_debouncer (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  ddkmd_pkg::in_item_t                 in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output ddkmd_pkg::out_item_t                out_data_o,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [ddkmd_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [ddkmd_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [ddkmd_pkg::APB_DATA_W-1:0]    prdata,
  output logic                                pready
);

  logic [ddkmd_pkg::CNT_W-1:0] debounce_scans_q, debounce_scans_d;
  logic                        reg_sel;
  logic                        reg_write;

  logic            front_valid, front_ready;
  ddkmd_pkg::cmd_t front_cmd;
  logic            queue_valid, queue_ready;
  ddkmd_pkg::cmd_t queue_cmd;

  // The register port never inserts wait states. Byte address bit two
  // selects the register; writes beyond the single register are dropped.
  assign pready    = 1'b1;
  assign reg_sel   = paddr[ddkmd_pkg::APB_ADDR_W-1] == ddkmd_pkg::REG_DEBOUNCE_SCANS;
  assign reg_write = psel && penable && pwrite && pready;

  always_comb begin
    debounce_scans_d = debounce_scans_q;
    if (reg_write && reg_sel) begin
      debounce_scans_d = pwdata[ddkmd_pkg::CNT_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_sel) begin
      prdata = ddkmd_pkg::APB_DATA_W'(debounce_scans_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_scans_q <= ddkmd_pkg::DEBOUNCE_RESET;
    end else begin
      debounce_scans_q <= debounce_scans_d;
    end
  end

  // The front end registers and classifies each line sample.
  ddkmd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .cmd_valid_o (front_valid),
    .cmd_ready_i (front_ready),
    .cmd_o       (front_cmd)
  );

  // The queue lets the front end keep accepting while a publication drains.
  ddkmd_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (front_valid),
    .push_ready_o (front_ready),
    .push_cmd_i   (front_cmd),
    .pop_valid_o  (queue_valid),
    .pop_ready_i  (queue_ready),
    .pop_cmd_o    (queue_cmd)
  );

  // The back end owns the debounce state and publishes the matrix.
  ddkmd_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .debounce_scans_i (debounce_scans_q),
    .cmd_valid_i      (queue_valid),
    .cmd_ready_o      (queue_ready),
    .cmd_i            (queue_cmd),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .out_data_o       (out_data_o)
  );

endmodule

### src/ddkmd_front.sv
module ddkmd_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  ddkmd_pkg::in_item_t in_data_i,
  output logic                cmd_valid_o,
  input  logic                cmd_ready_i,
  output ddkmd_pkg::cmd_t     cmd_o
);

  logic            cmd_valid_q, cmd_valid_d;
  ddkmd_pkg::cmd_t cmd_q, cmd_d;
  logic            accept;

  assign in_ready_o  = !cmd_valid_q || cmd_ready_i;
  assign accept      = in_valid_i && in_ready_o;
  assign cmd_valid_o = cmd_valid_q;
  assign cmd_o       = cmd_q;

  // Invert the active-low pins, drop lines that are not fitted and flag an
  // out-of-range driven line so the back end leaves its state alone.
  always_comb begin
    cmd_d.dir  = ddkmd_pkg::dir_e'(in_data_i.direction);
    cmd_d.line = in_data_i.line_index;
    cmd_d.eoh  = in_data_i.end_of_half;
    if (in_data_i.direction == ddkmd_pkg::DIR_COLS) begin
      cmd_d.line_ok = {1'b0, in_data_i.line_index} < 4'(ddkmd_pkg::KEPT_COLS);
      cmd_d.keys    = ~in_data_i.pin_levels & ddkmd_pkg::ROW_MASK;
    end else begin
      cmd_d.line_ok = {1'b0, in_data_i.line_index} < 4'(ddkmd_pkg::KEPT_ROWS);
      cmd_d.keys    = ~in_data_i.pin_levels & ddkmd_pkg::COL_MASK;
    end
  end

  always_comb begin
    cmd_valid_d = cmd_valid_q;
    if (accept) begin
      cmd_valid_d = 1'b1;
    end else if (cmd_ready_i) begin
      cmd_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_valid_q <= 1'b0;
    end else begin
      cmd_valid_q <= cmd_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= cmd_d;
    end
  end

endmodule

### src/ddkmd_fifo.sv
module ddkmd_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_valid_i,
  output logic            push_ready_o,
  input  ddkmd_pkg::cmd_t push_cmd_i,
  output logic            pop_valid_o,
  input  logic            pop_ready_i,
  output ddkmd_pkg::cmd_t pop_cmd_o
);

  ddkmd_pkg::cmd_t                         mem_q [ddkmd_pkg::QUEUE_DEPTH];
  logic [ddkmd_pkg::QUEUE_PTR_W-1:0]       wr_ptr_q, wr_ptr_d;
  logic [ddkmd_pkg::QUEUE_PTR_W-1:0]       rd_ptr_q, rd_ptr_d;
  logic [ddkmd_pkg::QUEUE_CNT_W-1:0]       count_q, count_d;
  logic                                    push, pop;

  localparam logic [ddkmd_pkg::QUEUE_PTR_W-1:0] LastPtr =
    ddkmd_pkg::QUEUE_PTR_W'(ddkmd_pkg::QUEUE_DEPTH - 1);
  localparam logic [ddkmd_pkg::QUEUE_CNT_W-1:0] FullCount =
    ddkmd_pkg::QUEUE_CNT_W'(ddkmd_pkg::QUEUE_DEPTH);

  assign push_ready_o = count_q != FullCount;
  assign pop_valid_o  = count_q != '0;
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_cmd_o    = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

### src/ddkmd_back.sv
module ddkmd_back (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic [ddkmd_pkg::CNT_W-1:0]     debounce_scans_i,
  input  logic                            cmd_valid_i,
  output logic                            cmd_ready_o,
  input  ddkmd_pkg::cmd_t                 cmd_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output ddkmd_pkg::out_item_t            out_data_o
);

  logic [ddkmd_pkg::KEY_W-1:0] rows_q [ddkmd_pkg::TOTAL_ROWS];
  logic [ddkmd_pkg::KEY_W-1:0] rows_d [ddkmd_pkg::TOTAL_ROWS];
  logic [ddkmd_pkg::KEY_W-1:0] tbuf_q [ddkmd_pkg::KEPT_LINES];
  logic [ddkmd_pkg::KEY_W-1:0] tbuf_d [ddkmd_pkg::KEPT_LINES];
  logic [ddkmd_pkg::CNT_W-1:0] cnt_q, cnt_d, cnt_mid;

  logic                           pub_active_q, pub_active_d;
  logic [ddkmd_pkg::ROW_NUM_W-1:0] pub_cnt_q, pub_cnt_d;
  logic                           out_valid_q, out_valid_d;
  ddkmd_pkg::out_item_t           out_q;

  logic                           take, changed, pub_start, load;
  logic [ddkmd_pkg::ROW_NUM_W-1:0] rd_addr;
  logic [ddkmd_pkg::KEY_W-1:0]    rd_row;

  // While a matrix is being published no command is taken, so the stored
  // rows stay frozen for the whole burst.
  assign cmd_ready_o = !pub_active_q;
  assign take        = cmd_valid_i && !pub_active_q;
  assign load        = pub_active_q && (!out_valid_q || out_ready_i);

  // One shared read port: the publish counter, or the driven row.
  assign rd_addr = pub_active_q ? pub_cnt_q : {1'b0, cmd_i.line};
  assign rd_row  = rows_q[rd_addr];

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    rows_d    = rows_q;
    tbuf_d    = tbuf_q;
    cnt_d     = cnt_q;
    cnt_mid   = cnt_q;
    changed   = 1'b0;
    pub_start = 1'b0;
    if (take) begin
      if (cmd_i.dir == ddkmd_pkg::DIR_ROWS) begin
        if (cmd_i.line_ok && (rd_row != cmd_i.keys)) begin
          rows_d[{1'b0, cmd_i.line}] = cmd_i.keys;
          changed = 1'b1;
        end
      end else begin
        if (cmd_i.line_ok) begin
          for (int i = 0; i < ddkmd_pkg::KEPT_ROWS; i++) begin
            tbuf_d[i][cmd_i.line] = cmd_i.keys[i];
          end
        end
        // The upper half is compared only once the column half is complete.
        if (cmd_i.eoh) begin
          for (int i = 0; i < ddkmd_pkg::KEPT_ROWS; i++) begin
            if (rows_q[ddkmd_pkg::HALF_ROWS + i] != tbuf_d[i]) begin
              rows_d[ddkmd_pkg::HALF_ROWS + i] = tbuf_d[i];
              changed = 1'b1;
            end
          end
        end
      end
      cnt_mid = changed ? debounce_scans_i : cnt_q;
      cnt_d   = cnt_mid;
      if (cmd_i.eoh && (cnt_mid != '0)) begin
        cnt_d = cnt_mid - 1'b1;
        if (cnt_mid == ddkmd_pkg::CNT_W'(1)) begin
          pub_start = 1'b1;
        end
      end
    end
  end

  always_comb begin
    pub_active_d = pub_active_q;
    pub_cnt_d    = pub_cnt_q;
    out_valid_d  = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (pub_start) begin
      pub_active_d = 1'b1;
      pub_cnt_d    = '0;
    end else if (load) begin
      out_valid_d = 1'b1;
      pub_cnt_d   = pub_cnt_q + 1'b1;
      if (pub_cnt_q == ddkmd_pkg::LAST_ROW_NUM) begin
        pub_active_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ddkmd_pkg::TOTAL_ROWS; i++) begin
        rows_q[i] <= '0;
      end
      for (int i = 0; i < ddkmd_pkg::KEPT_LINES; i++) begin
        tbuf_q[i] <= '0;
      end
      cnt_q        <= ddkmd_pkg::DEBOUNCE_RESET;
      pub_active_q <= 1'b0;
      pub_cnt_q    <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      rows_q       <= rows_d;
      tbuf_q       <= tbuf_d;
      cnt_q        <= cnt_d;
      pub_active_q <= pub_active_d;
      pub_cnt_q    <= pub_cnt_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q.row_number <= pub_cnt_q;
      out_q.row_keys   <= rd_row;
      out_q.last_row   <= pub_cnt_q == ddkmd_pkg::LAST_ROW_NUM;
    end
  end

endmodule

### bench/tb_top.sv
module tb_top;

  // Clock, run length and pacing.
  localparam int HALF_PERIOD   = 5;
  localparam int RESET_CYCLES  = 8;
  localparam int CYCLE_LIMIT   = 200_000;
  // Cycles given to the block after the last expected row, so that samples that
  // publish nothing have left the input register and the command queue.
  localparam int SETTLE_CYCLES = 12;
  localparam int TAIL_CYCLES   = 40;
  localparam int HOLD_CYCLES   = 300;

  // Random phases. Each one runs under its own debounce_scans setting.
  localparam int NUM_PHASES    = 6;
  localparam int PHASE_ITEMS   = 60;
  localparam int PHASE_SPARE   = 1;  // Also writes the unused register address.
  localparam int PHASE_HOLD    = 2;  // The consumer stalls for a long stretch.
  localparam int PHASE_QUIET   = 3;  // Neither side inserts gaps.
  localparam int PHASE_RANDOM  = 4;  // debounce_scans drawn at random.

  // Register map: one register, word aligned.
  localparam logic [ddkmd_pkg::APB_ADDR_W-1:0] ADDR_SCANS  =
    {ddkmd_pkg::REG_DEBOUNCE_SCANS, 2'b00};
  localparam logic [ddkmd_pkg::APB_ADDR_W-1:0] ADDR_UNUSED =
    {~ddkmd_pkg::REG_DEBOUNCE_SCANS, 2'b00};

  // How the expected rows of a directed step are obtained: from the predictor,
  // typed in as "no rows at all", or typed in as a full matrix of one value.
  typedef enum logic [1:0] {
    EXP_PREDICT,
    EXP_NOTHING,
    EXP_UNIFORM
  } exp_kind_e;

  typedef struct {
    ddkmd_pkg::dir_e              dir;
    logic [ddkmd_pkg::LINE_W-1:0] line;
    logic [ddkmd_pkg::KEY_W-1:0]  pins;
    logic                         eoh;
    exp_kind_e                    kind;
    logic [ddkmd_pkg::KEY_W-1:0]  fill;
  } directed_step_t;

  localparam int NUM_DIRECTED = 24;

  // Directed stimulus. Reset leaves the countdown at two, so two quiet ends of
  // half publish the empty matrix, after which the idle countdown stays put.
  // Then every key is pressed, first through the rows and then through the
  // columns, and one more quiet half publishes a matrix of all ones. The last
  // rows mix patterns in both directions and are left to the predictor.
  directed_step_t directed_steps [NUM_DIRECTED] = '{
    '{ddkmd_pkg::DIR_ROWS, 3'd0, 8'hFF, 1'b1, EXP_NOTHING, 8'h00},
    '{ddkmd_pkg::DIR_ROWS, 3'd7, 8'hFF, 1'b1, EXP_UNIFORM, 8'h00},
    '{ddkmd_pkg::DIR_ROWS, 3'd0, 8'hFF, 1'b1, EXP_NOTHING, 8'h00},
    '{ddkmd_pkg::DIR_ROWS, 3'd0, 8'h00, 1'b0, EXP_PREDICT, 8'h00},
    '{ddkmd_pkg::DIR_ROWS, 3'd1, 8'h00, 1'b0, EXP_PREDICT, 8'h00},
    '{ddkmd_pkg::DIR_ROWS, 3'd2, 8'h00, 1'b0, EXP_PREDICT, 8'h00},
    '{ddkmd_pkg::DIR_ROWS, 3'd3, 8'h00, 1'b0, EXP_PREDICT, 8'h00},
    '{ddkmd_pkg::DIR_ROWS, 3'd4, 8'h00, 1'b0, EXP_PREDICT, 8'h00},
    '{ddkmd_pkg::DIR_ROWS, 3'd5, 8'h00, 1'b0, EXP_PREDICT, 8'h00},
    '{ddkmd_pkg::DIR_ROWS, 3'd6, 8'h00, 1'b0, EXP_PREDICT, 8'h00},
    '{ddkmd_pkg::DIR_ROWS, 3'd7, 8'h00, 1'b1, EXP_PREDICT, 8'h00},
    '{ddkmd_pkg::DIR_COLS, 3'd0, 8'h00, 1'b0, EXP_PREDICT, 8'h00},
    '{ddkmd_pkg::DIR_COLS, 3'd1, 8'h00, 1'b0, EXP_PREDICT, 8'h00},
    '{ddkmd_pkg::DIR_COLS, 3'd2, 8'h00, 1'b0, EXP_PREDICT, 8'h00},
    '{ddkmd_pkg::DIR_COLS, 3'd3, 8'h00, 1'b0, EXP_PREDICT, 8'h00},
    '{ddkmd_pkg::DIR_COLS, 3'd4, 8'h00, 1'b0, EXP_PREDICT, 8'h00},
    '{ddkmd_pkg::DIR_COLS, 3'd5, 8'h00, 1'b0, EXP_PREDICT, 8'h00},
    '{ddkmd_pkg::DIR_COLS, 3'd6, 8'h00, 1'b0, EXP_PREDICT, 8'h00},
    '{ddkmd_pkg::DIR_COLS, 3'd7, 8'h00, 1'b1, EXP_PREDICT, 8'h00},
    '{ddkmd_pkg::DIR_COLS, 3'd3, 8'h00, 1'b1, EXP_UNIFORM, 8'hFF},
    '{ddkmd_pkg::DIR_ROWS, 3'd5, 8'h55, 1'b0, EXP_PREDICT, 8'h00},
    '{ddkmd_pkg::DIR_COLS, 3'd6, 8'hAA, 1'b1, EXP_PREDICT, 8'h00},
    '{ddkmd_pkg::DIR_ROWS, 3'd2, 8'hFE, 1'b1, EXP_PREDICT, 8'h00},
    '{ddkmd_pkg::DIR_ROWS, 3'd2, 8'hFE, 1'b1, EXP_PREDICT, 8'h00}
  };

  logic                             clk_i;
  logic                             rst_ni;
  logic                             in_valid_i;
  logic                             in_ready_o;
  ddkmd_pkg::in_item_t              in_data_i;
  logic                             out_valid_o;
  logic                             out_ready_i;
  ddkmd_pkg::out_item_t             out_data_o;
  logic                             psel;
  logic                             penable;
  logic                             pwrite;
  logic [ddkmd_pkg::APB_ADDR_W-1:0] paddr;
  logic [ddkmd_pkg::APB_DATA_W-1:0] pwdata;
  logic [ddkmd_pkg::APB_DATA_W-1:0] prdata;
  logic                             pready;

  // Shadow of the block's state, kept by the predictor.
  logic [ddkmd_pkg::KEY_W-1:0] shadow_rows      [ddkmd_pkg::TOTAL_ROWS];
  logic [ddkmd_pkg::KEY_W-1:0] shadow_transpose [ddkmd_pkg::KEPT_LINES];
  logic [ddkmd_pkg::CNT_W-1:0] shadow_countdown;
  logic [ddkmd_pkg::CNT_W-1:0] shadow_scans;

  // Rows still owed by the block, oldest first.
  ddkmd_pkg::out_item_t pending_rows [$];

  // The key pattern that the random scans read out, rows 0 to 15, and the
  // samples of the current phase.
  logic [ddkmd_pkg::KEY_W-1:0] keys_held [ddkmd_pkg::TOTAL_ROWS];
  ddkmd_pkg::in_item_t         scan_items [$];

  int  errors       = 0;
  int  cycle_count  = 0;
  int  items_sent   = 0;
  int  rows_checked = 0;
  int  publications = 0;
  bit  quiet_mode   = 1'b0;
  bit  hold_out     = 1'b0;

  dual_direction_key_matrix_debouncer u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  initial clk_i = 1'b0;
  always #HALF_PERIOD clk_i = ~clk_i;

  // The watchdog. Its limit is several times the slowest legal run: every
  // sample publishing sixteen rows against the longest consumer stall.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d rows still owed", $time, cycle_count,
               pending_rows.size());
      $display("tb_top: FAIL");
      $finish;
    end
  end

  // A changed row is stored and reloads the shared countdown.
  function automatic void shadow_store(int idx, logic [ddkmd_pkg::KEY_W-1:0] keys);
    if (shadow_rows[idx] != keys) begin
      shadow_rows[idx] = keys;
      shadow_countdown = shadow_scans;
    end
  endfunction

  // Applies one accepted line sample to the shadow state. Returns 1 when the
  // countdown runs out, that is when the whole matrix gets published.
  function automatic bit debounce_predict(ddkmd_pkg::in_item_t smp);
    logic [ddkmd_pkg::KEY_W-1:0] pressed;
    pressed = ~smp.pin_levels;
    // The sample itself comes first: a row compare, or a column written into
    // the transpose buffer one bit per sensed row.
    if (ddkmd_pkg::dir_e'(smp.direction) == ddkmd_pkg::DIR_ROWS) begin
      if (smp.line_index < ddkmd_pkg::KEPT_ROWS) begin
        shadow_store(smp.line_index, pressed & ddkmd_pkg::COL_MASK);
      end
    end else if (smp.line_index < ddkmd_pkg::KEPT_COLS) begin
      pressed = pressed & ddkmd_pkg::ROW_MASK;
      for (int j = 0; j < ddkmd_pkg::KEPT_ROWS; j++) begin
        shadow_transpose[j][smp.line_index] = pressed[j];
      end
    end
    if (!smp.end_of_half) return 1'b0;
    // At the end of a column half the buffer is compared with the upper half.
    if (ddkmd_pkg::dir_e'(smp.direction) == ddkmd_pkg::DIR_COLS) begin
      for (int j = 0; j < ddkmd_pkg::KEPT_ROWS; j++) begin
        shadow_store(ddkmd_pkg::HALF_ROWS + j, shadow_transpose[j]);
      end
    end
    // An idle countdown stays at zero, so a stable matrix is published once.
    if (shadow_countdown == '0) return 1'b0;
    shadow_countdown = shadow_countdown - 1'b1;
    return shadow_countdown == '0;
  endfunction

  // One register access, setup cycle then access cycle. Read data is taken at
  // the edge that completes the access.
  task automatic apb_access(input bit is_write,
                            input logic [ddkmd_pkg::APB_ADDR_W-1:0] addr,
                            input logic [ddkmd_pkg::APB_DATA_W-1:0] wdata,
                            output logic [ddkmd_pkg::APB_DATA_W-1:0] rdata);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= is_write;
    paddr   <= addr;
    pwdata  <= wdata;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    rdata = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (is_write && addr == ADDR_SCANS) shadow_scans = wdata[ddkmd_pkg::CNT_W-1:0];
  endtask

  task automatic check_scans(input logic [ddkmd_pkg::CNT_W-1:0] want);
    logic [ddkmd_pkg::APB_DATA_W-1:0] rd;
    apb_access(1'b0, ADDR_SCANS, '0, rd);
    if (rd[ddkmd_pkg::CNT_W-1:0] !== want) begin
      errors++;
      $display("%0t: debounce_scans read back: expected %0d, actual %0d", $time, want,
               rd[ddkmd_pkg::CNT_W-1:0]);
    end
  endtask

  // Waits until every owed row has arrived, then lets in-flight samples drain.
  task automatic wait_idle();
    while (pending_rows.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Offers one sample, called at a falling edge. Valid stays high from one
  // transfer to the next when no gap is drawn. The expected rows are queued
  // at the edge that accepts the sample.
  task automatic send_item(input ddkmd_pkg::in_item_t smp, input exp_kind_e kind,
                           input logic [ddkmd_pkg::KEY_W-1:0] fill);
    int                   gap;
    bit                   pub;
    ddkmd_pkg::out_item_t row;
    gap = quiet_mode ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= smp;
    do @(posedge clk_i); while (!in_ready_o);
    items_sent++;
    pub = debounce_predict(smp);
    if (kind == EXP_UNIFORM || (kind == EXP_PREDICT && pub)) begin
      publications++;
      for (int r = 0; r < ddkmd_pkg::TOTAL_ROWS; r++) begin
        row.row_number = ddkmd_pkg::ROW_NUM_W'(r);
        row.row_keys   = (kind == EXP_UNIFORM) ? fill : shadow_rows[r];
        row.last_row   = (row.row_number == ddkmd_pkg::LAST_ROW_NUM);
        pending_rows.push_back(row);
      end
    end
    @(negedge clk_i);
  endtask

  // The consumer. Before each transfer it may hold ready low at random;
  // once, on request, it holds ready low for a long stretch so that
  // the output register, the command queue and the input register fill up
  // and the block stalls its input while samples are still being offered.
  initial begin : consumer
    int stall;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_out) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_out = 1'b0;
      end
      stall = quiet_mode ? 0 : $urandom_range(0, 3);
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // Every output transfer is compared with the oldest owed row.
  always @(posedge clk_i) begin : row_checker
    ddkmd_pkg::out_item_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      rows_checked++;
      if (pending_rows.size() == 0) begin
        errors++;
        $display("%0t: unexpected row: expected none, actual row %0d keys %h last %b", $time,
                 out_data_o.row_number, out_data_o.row_keys, out_data_o.last_row);
      end else begin
        want = pending_rows.pop_front();
        if (out_data_o.row_number !== want.row_number || out_data_o.row_keys !== want.row_keys
            || out_data_o.last_row !== want.last_row) begin
          errors++;
          $display("%0t: row mismatch: expected row %0d keys %h last %b, %s",
                   $time, want.row_number, want.row_keys, want.last_row,
                   $sformatf("actual row %0d keys %h last %b", out_data_o.row_number,
                             out_data_o.row_keys, out_data_o.last_row));
        end
      end
    end
  end

  initial begin : main
    logic [ddkmd_pkg::APB_DATA_W-1:0] rd;
    logic [ddkmd_pkg::CNT_W-1:0]      scans;
    logic [ddkmd_pkg::KEY_W-1:0]      col;
    ddkmd_pkg::in_item_t              smp;
    ddkmd_pkg::dir_e                  scan_dir;
    int                               r;
    int                               b;
    int                               lines;

    // Every input known from time zero while reset is held.
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    in_data_i  = '0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    shadow_scans     = ddkmd_pkg::DEBOUNCE_RESET;
    shadow_countdown = ddkmd_pkg::DEBOUNCE_RESET;
    foreach (shadow_rows[i]) shadow_rows[i] = '0;
    foreach (shadow_transpose[i]) shadow_transpose[i] = '0;
    foreach (keys_held[i]) keys_held[i] = '0;
    scan_dir = ddkmd_pkg::DIR_ROWS;
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    check_scans(ddkmd_pkg::DEBOUNCE_RESET);

    // Directed part, run under the reset value of debounce_scans.
    @(negedge clk_i);
    foreach (directed_steps[i]) begin
      smp.direction   = directed_steps[i].dir;
      smp.line_index  = directed_steps[i].line;
      smp.pin_levels  = directed_steps[i].pins;
      smp.end_of_half = directed_steps[i].eoh;
      send_item(smp, directed_steps[i].kind, directed_steps[i].fill);
    end
    in_valid_i <= 1'b0;
    wait_idle();

    // Random phases. Most samples are complete half scans read from a key
    // pattern that changes now and then, with an occasional bouncing pin;
    // the rest are bursts of samples with every field random, which also
    // break up half scans at random points.
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0:            scans = '0;  // Zero reload: changes only clear the countdown.
        1:            scans = '1;
        2:            scans = ddkmd_pkg::CNT_W'(1);
        3:            scans = ddkmd_pkg::CNT_W'(3);
        PHASE_RANDOM: scans = ddkmd_pkg::CNT_W'($urandom_range(1, 254));
        default:      scans = ddkmd_pkg::DEBOUNCE_RESET;
      endcase
      apb_access(1'b1, ADDR_SCANS, ddkmd_pkg::APB_DATA_W'(scans), rd);
      check_scans(shadow_scans);
      if (ph == PHASE_SPARE) begin
        // A write to an address with no register behind it changes nothing.
        apb_access(1'b1, ADDR_UNUSED, ddkmd_pkg::APB_DATA_W'($urandom), rd);
        check_scans(shadow_scans);
      end
      quiet_mode = (ph == PHASE_QUIET);
      hold_out   = (ph == PHASE_HOLD);

      scan_items.delete();
      while (scan_items.size() < PHASE_ITEMS) begin
        if ($urandom_range(0, 4) != 0) begin
          scan_dir = (scan_dir == ddkmd_pkg::DIR_ROWS) ? ddkmd_pkg::DIR_COLS
                                                       : ddkmd_pkg::DIR_ROWS;
          if ($urandom_range(0, 2) == 0) begin
            r = $urandom_range(0, ddkmd_pkg::TOTAL_ROWS - 1);
            b = $urandom_range(0, ddkmd_pkg::KEY_W - 1);
            keys_held[r][b] = ~keys_held[r][b];
          end
          lines = (scan_dir == ddkmd_pkg::DIR_ROWS) ? ddkmd_pkg::KEPT_ROWS
                                                    : ddkmd_pkg::KEPT_COLS;
          for (int ln = 0; ln < lines; ln++) begin
            for (int j = 0; j < ddkmd_pkg::KEPT_ROWS; j++) begin
              col[j] = keys_held[ddkmd_pkg::HALF_ROWS + j][ln];
            end
            smp.direction   = scan_dir;
            smp.line_index  = ddkmd_pkg::LINE_W'(ln);
            smp.pin_levels  = ~((scan_dir == ddkmd_pkg::DIR_ROWS) ? keys_held[ln] : col);
            smp.end_of_half = (ln == lines - 1);
            if ($urandom_range(0, 15) == 0) begin
              b = $urandom_range(0, ddkmd_pkg::KEY_W - 1);
              smp.pin_levels[b] = ~smp.pin_levels[b];
            end
            scan_items.push_back(smp);
          end
        end else begin
          repeat ($urandom_range(1, 3)) begin
            smp = ddkmd_pkg::in_item_t'($bits(ddkmd_pkg::in_item_t)'($urandom));
            scan_items.push_back(smp);
          end
        end
      end

      @(negedge clk_i);
      foreach (scan_items[i]) send_item(scan_items[i], EXP_PREDICT, '0);
      in_valid_i <= 1'b0;
      wait_idle();
      quiet_mode = 1'b0;
    end

    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (pending_rows.size() != 0) begin
      errors++;
      $display("%0t: %0d expected rows never arrived", $time, pending_rows.size());
    end

    $display("Sent %0d line samples in both directions; checked %0d rows of %0d publications.",
             items_sent, rows_checked, publications);
    $display("debounce_scans ran at 0, 1, 2, 3, 255 and a random value, with one long stall.");
    if (errors == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("%0d mismatches", errors);
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
